// ----- hdl/vtpd_pkg.sv -----
// Shared constants, command structs and state encoding for the vertex transform block.
package vtpd_pkg;

  // Fixed-point format and field widths.
  localparam int FRAC_BITS = 16;
  localparam int COORD_W   = 32;
  localparam int IDX_W     = 4;
  localparam int ROW_W     = IDX_W / 2;
  localparam int MAT_DEPTH = 1 << IDX_W;

  // Datapath widths: a 32x32 product, a sum of three products, and the
  // column sum after the fractional shift plus the translation term.
  localparam int PROD_W = 2 * COORD_W;
  localparam int ACC_W  = PROD_W + 2;
  localparam int SUM_W  = ACC_W - FRAC_BITS + 1;
  localparam int MAG_W  = SUM_W;

  // Sequencing counts.
  localparam int ISSUE_CNT  = MAT_DEPTH;
  localparam int DRAIN_CNT  = 2;
  localparam int DIV_STEPS  = COORD_W;
  localparam int CNT_W      = $clog2(DIV_STEPS);
  localparam int NUM_LANES  = 3;

  // Operation codes on the input channel.
  typedef enum logic [0:0] {
    OP_LOAD  = 1'b0,
    OP_XFORM = 1'b1
  } op_e;

  // Controller states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ISSUE,
    ST_DRAIN,
    ST_PREP,
    ST_START,
    ST_DIV,
    ST_DONE
  } ctrl_state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic             wr_en;
    logic             load_vtx;
    logic             issue_en;
    logic [IDX_W-1:0] issue_addr;
    logic             prep_en;
    logic             div_start;
    logic             div_step;
    logic             out_load;
  } ctrl_cmd_t;

  // Commands from the datapath to each divider lane.
  typedef struct packed {
    logic start;
    logic step;
  } div_cmd_t;

endpackage

// ----- hdl/vtpd_ifs.sv -----
// Valid/ready channel interfaces for vertex items and transformed results.
interface vtpd_in_if;
  logic                                 valid;
  logic                                 ready;
  vtpd_pkg::op_e                        op;
  logic [vtpd_pkg::IDX_W-1:0]           elem_index;
  logic signed [vtpd_pkg::COORD_W-1:0]  elem_value;
  logic signed [vtpd_pkg::COORD_W-1:0]  vx;
  logic signed [vtpd_pkg::COORD_W-1:0]  vy;
  logic signed [vtpd_pkg::COORD_W-1:0]  vz;

  modport source (
    output valid, op, elem_index, elem_value, vx, vy, vz,
    input  ready
  );
  modport sink (
    input  valid, op, elem_index, elem_value, vx, vy, vz,
    output ready
  );
endinterface

interface vtpd_out_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [vtpd_pkg::COORD_W-1:0]  out_x;
  logic signed [vtpd_pkg::COORD_W-1:0]  out_y;
  logic signed [vtpd_pkg::COORD_W-1:0]  out_z;
  logic                                 w_was_zero;

  modport source (
    output valid, out_x, out_y, out_z, w_was_zero,
    input  ready
  );
  modport sink (
    input  valid, out_x, out_y, out_z, w_was_zero,
    output ready
  );
endinterface

// ----- hdl/vertex_transform_perspective_divide.sv -----
// Top level: 4x4 homogeneous vertex transform with perspective divide.
// Load beats write one matrix element and are taken one per cycle while the controller is idle.
// A transform beat passes through the matrix reads, the pipeline drain, operand setup, the divide
// steps and the result register load before its result is valid.
// A new beat is accepted once the controller is back in idle.
// Reset (rst_ni low, asynchronous) clears control and valid flags; the matrix is undefined.
module vertex_transform_perspective_divide (
  input logic         clk_i,
  input logic         rst_ni,
  vtpd_in_if.sink     in_chan_i,
  vtpd_out_if.source  out_chan_o
);
  import vtpd_pkg::*;

  ctrl_cmd_t cmd;

  vtpd_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_chan_i.valid),
    .in_op_i     (in_chan_i.op),
    .out_ready_i (out_chan_o.ready),
    .in_ready_o  (in_chan_i.ready),
    .out_valid_o (out_chan_o.valid),
    .cmd_o       (cmd)
  );

  vtpd_datapath u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .elem_index_i (in_chan_i.elem_index),
    .elem_value_i (in_chan_i.elem_value),
    .vx_i         (in_chan_i.vx),
    .vy_i         (in_chan_i.vy),
    .vz_i         (in_chan_i.vz),
    .out_x_o      (out_chan_o.out_x),
    .out_y_o      (out_chan_o.out_y),
    .out_z_o      (out_chan_o.out_z),
    .w_was_zero_o (out_chan_o.w_was_zero)
  );

endmodule

// ----- hdl/vtpd_divider.sv -----
// One lane of the restoring divider: (a << FRAC_BITS) / d, one quotient bit per cycle.
module vtpd_divider (
  input  logic                                clk_i,
  input  vtpd_pkg::div_cmd_t                  cmd_i,
  input  logic [vtpd_pkg::MAG_W-1:0]          a_i,
  input  logic [vtpd_pkg::MAG_W-1:0]          d_i,
  input  logic                                neg_i,
  output logic signed [vtpd_pkg::COORD_W-1:0] quo_o
);
  import vtpd_pkg::*;

  localparam int SHIFT = COORD_W - FRAC_BITS;
  localparam int SAT_W = MAG_W + SHIFT;

  logic [MAG_W-1:0]   rem_q, rem_d;
  logic [COORD_W-1:0] low_q, low_d;
  logic [COORD_W-1:0] quo_q, quo_d;
  logic               sat_q, sat_d;
  logic               neg_q, neg_d;
  logic [MAG_W:0]     trial;
  logic [MAG_W:0]     diff;
  logic               fits;
  logic [COORD_W-1:0] limit;
  logic [COORD_W-1:0] clamped;

  // Trial subtraction of the divisor from the shifted partial remainder.
  always_comb begin
    trial = {rem_q, low_q[COORD_W-1]};
    diff  = trial - {1'b0, d_i};
    fits  = trial >= {1'b0, d_i};
  end

  // Next state: load the operands on start, shift in one bit per step.
  always_comb begin
    rem_d = rem_q;
    low_d = low_q;
    quo_d = quo_q;
    sat_d = sat_q;
    neg_d = neg_q;
    if (cmd_i.start) begin
      // The quotient overflows 32 bits when a / d reaches 2^(32-FRAC_BITS).
      sat_d = SAT_W'(a_i) >= (SAT_W'(d_i) << SHIFT);
      rem_d = a_i >> SHIFT;
      low_d = {a_i[SHIFT-1:0], {FRAC_BITS{1'b0}}};
      quo_d = '0;
      neg_d = neg_i;
    end else if (cmd_i.step) begin
      rem_d = fits ? diff[MAG_W-1:0] : trial[MAG_W-1:0];
      low_d = {low_q[COORD_W-2:0], 1'b0};
      quo_d = {quo_q[COORD_W-2:0], fits};
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    low_q <= low_d;
    quo_q <= quo_d;
    sat_q <= sat_d;
    neg_q <= neg_d;
  end

  // Saturate to the signed 32-bit range, then apply the sign.
  always_comb begin
    limit   = neg_q ? {1'b1, {(COORD_W-1){1'b0}}} : {1'b0, {(COORD_W-1){1'b1}}};
    clamped = (sat_q || (quo_q > limit)) ? limit : quo_q;
    quo_o   = neg_q ? $signed(-clamped) : $signed(clamped);
  end

endmodule

// ----- hdl/vtpd_datapath.sv -----
// Matrix store, shared multiply-accumulate pipeline, divider lanes and result register.
module vtpd_datapath (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  vtpd_pkg::ctrl_cmd_t                 cmd_i,
  input  logic [vtpd_pkg::IDX_W-1:0]          elem_index_i,
  input  logic signed [vtpd_pkg::COORD_W-1:0] elem_value_i,
  input  logic signed [vtpd_pkg::COORD_W-1:0] vx_i,
  input  logic signed [vtpd_pkg::COORD_W-1:0] vy_i,
  input  logic signed [vtpd_pkg::COORD_W-1:0] vz_i,
  output logic signed [vtpd_pkg::COORD_W-1:0] out_x_o,
  output logic signed [vtpd_pkg::COORD_W-1:0] out_y_o,
  output logic signed [vtpd_pkg::COORD_W-1:0] out_z_o,
  output logic                                w_was_zero_o
);
  import vtpd_pkg::*;

  localparam logic [ROW_W-1:0] ROW_FIRST = '0;
  localparam logic [ROW_W-1:0] ROW_TRANS = '1;

  // Magnitude of a signed column sum.
  function automatic logic [MAG_W-1:0] abs_mag(input logic signed [SUM_W-1:0] v);
    abs_mag = v[SUM_W-1] ? MAG_W'(-v) : MAG_W'(v);
  endfunction

  // Clamp a column sum to the signed 32-bit range.
  function automatic logic signed [COORD_W-1:0] sat_coord(input logic signed [SUM_W-1:0] v);
    logic [SUM_W-COORD_W:0] top;
    top = v[SUM_W-1:COORD_W-1];
    if ((&top) || !(|top)) begin
      sat_coord = v[COORD_W-1:0];
    end else if (v[SUM_W-1]) begin
      sat_coord = {1'b1, {(COORD_W-1){1'b0}}};
    end else begin
      sat_coord = {1'b0, {(COORD_W-1){1'b1}}};
    end
  endfunction

  logic signed [COORD_W-1:0] mem [MAT_DEPTH];

  logic signed [COORD_W-1:0] vx_q, vy_q, vz_q;

  // Stage 1: matrix read.
  logic signed [COORD_W-1:0] rd_q;
  logic                      v1_q;
  logic [ROW_W-1:0]          row1_q, col1_q;

  // Stage 2: product, or translation term.
  logic signed [COORD_W-1:0] vsel;
  logic signed [PROD_W-1:0]  prod_d, prod_q;
  logic signed [COORD_W-1:0] trans_q;
  logic                      v2_q;
  logic [ROW_W-1:0]          row2_q, col2_q;

  // Stage 3: accumulator and column sums.
  logic signed [ACC_W-1:0]   acc_q, acc_d;
  logic signed [SUM_W-1:0]   sum_q [NUM_LANES+1];
  logic signed [SUM_W-1:0]   sum_d;

  // Divider operands.
  logic [MAG_W-1:0]          mag_q [NUM_LANES];
  logic                      neg_q [NUM_LANES];
  logic [MAG_W-1:0]          wmag_q;
  logic                      wzero_q;
  div_cmd_t                  div_cmd;
  logic signed [COORD_W-1:0] quo [NUM_LANES];

  logic signed [COORD_W-1:0] out_x_q, out_y_q, out_z_q;
  logic                      w_was_zero_q;

  // Matrix store: written by load beats, read one element per issue cycle.
  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_en) begin
      mem[elem_index_i] <= elem_value_i;
    end
    if (cmd_i.issue_en) begin
      rd_q <= mem[cmd_i.issue_addr];
    end
  end

  // Vertex capture on a transform beat.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_vtx) begin
      vx_q <= vx_i;
      vy_q <= vy_i;
      vz_q <= vz_i;
    end
  end

  // Pipeline tags travel with the data.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      v1_q <= cmd_i.issue_en;
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    row1_q <= cmd_i.issue_addr[IDX_W-1:ROW_W];
    col1_q <= cmd_i.issue_addr[ROW_W-1:0];
    row2_q <= row1_q;
    col2_q <= col1_q;
  end

  // Shared multiplier: vertex coordinate chosen by the matrix row.
  always_comb begin
    unique case (row1_q)
      2'd0:    vsel = vx_q;
      2'd1:    vsel = vy_q;
      default: vsel = vz_q;
    endcase
    prod_d = vsel * rd_q;
  end

  always_ff @(posedge clk_i) begin
    if (v1_q) begin
      prod_q  <= prod_d;
      trans_q <= rd_q;
    end
  end

  // Accumulate three products, then floor-shift and add the translation term.
  always_comb begin
    acc_d = (row2_q == ROW_FIRST) ? ACC_W'(prod_q) : acc_q + ACC_W'(prod_q);
    sum_d = SUM_W'($signed(acc_q[ACC_W-1:FRAC_BITS])) + SUM_W'(trans_q);
  end

  always_ff @(posedge clk_i) begin
    if (v2_q) begin
      if (row2_q == ROW_TRANS) begin
        sum_q[col2_q] <= sum_d;
      end else begin
        acc_q <= acc_d;
      end
    end
  end

  // Operand preparation for the division.
  always_ff @(posedge clk_i) begin
    if (cmd_i.prep_en) begin
      for (int i = 0; i < NUM_LANES; i++) begin
        mag_q[i] <= abs_mag(sum_q[i]);
        neg_q[i] <= sum_q[i][SUM_W-1] ^ sum_q[NUM_LANES][SUM_W-1];
      end
      wmag_q  <= abs_mag(sum_q[NUM_LANES]);
      wzero_q <= (sum_q[NUM_LANES] == '0);
    end
  end

  assign div_cmd.start = cmd_i.div_start;
  assign div_cmd.step  = cmd_i.div_step;

  // Three divider lanes run together on the common divisor.
  for (genvar g = 0; g < NUM_LANES; g++) begin : g_lane
    vtpd_divider u_div (
      .clk_i  (clk_i),
      .cmd_i  (div_cmd),
      .a_i    (mag_q[g]),
      .d_i    (wmag_q),
      .neg_i  (neg_q[g]),
      .quo_o  (quo[g])
    );
  end

  // Result register: quotients, or clamped sums when w is zero.
  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_x_q      <= wzero_q ? sat_coord(sum_q[0]) : quo[0];
      out_y_q      <= wzero_q ? sat_coord(sum_q[1]) : quo[1];
      out_z_q      <= wzero_q ? sat_coord(sum_q[2]) : quo[2];
      w_was_zero_q <= wzero_q;
    end
  end

  assign out_x_o      = out_x_q;
  assign out_y_o      = out_y_q;
  assign out_z_o      = out_z_q;
  assign w_was_zero_o = w_was_zero_q;

endmodule

// ----- hdl/vtpd_ctrl.sv -----
// Controller state machine: sequences matrix reads, division steps and result hand-off.
module vtpd_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  vtpd_pkg::op_e       in_op_i,
  input  logic                out_ready_i,
  output logic                in_ready_o,
  output logic                out_valid_o,
  output vtpd_pkg::ctrl_cmd_t cmd_o
);
  import vtpd_pkg::*;

  localparam logic [CNT_W-1:0] ISSUE_LAST = CNT_W'(ISSUE_CNT - 1);
  localparam logic [CNT_W-1:0] DRAIN_LAST = CNT_W'(DRAIN_CNT - 1);
  localparam logic [CNT_W-1:0] DIV_LAST   = CNT_W'(DIV_STEPS - 1);

  ctrl_state_e      state_q, state_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             out_valid_q, out_valid_d;
  logic [IDX_W-1:0] k;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Issue order is column-major: the counter's high bits pick the column.
  assign k = cnt_q[IDX_W-1:0];

  // Next state and commands.
  always_comb begin
    state_d    = state_q;
    cnt_d      = cnt_q;
    in_ready_o = 1'b0;
    cmd_o      = '0;
    cmd_o.issue_addr = {k[ROW_W-1:0], k[IDX_W-1:ROW_W]};
    out_valid_d = out_valid_q && !out_ready_i;

    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        cnt_d      = '0;
        if (in_valid_i) begin
          if (in_op_i == OP_XFORM) begin
            cmd_o.load_vtx = 1'b1;
            state_d        = ST_ISSUE;
          end else begin
            cmd_o.wr_en = 1'b1;
          end
        end
      end
      ST_ISSUE: begin
        cmd_o.issue_en = 1'b1;
        cnt_d          = cnt_q + 1'b1;
        if (cnt_q == ISSUE_LAST) begin
          cnt_d   = '0;
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == DRAIN_LAST) begin
          cnt_d   = '0;
          state_d = ST_PREP;
        end
      end
      ST_PREP: begin
        cmd_o.prep_en = 1'b1;
        state_d       = ST_START;
      end
      ST_START: begin
        cmd_o.div_start = 1'b1;
        cnt_d           = '0;
        state_d         = ST_DIV;
      end
      ST_DIV: begin
        cmd_o.div_step = 1'b1;
        cnt_d          = cnt_q + 1'b1;
        if (cnt_q == DIV_LAST) begin
          cnt_d   = '0;
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        // Wait until the result register is free or being drained.
        if (!out_valid_q || out_ready_i) begin
          cmd_o.out_load = 1'b1;
          out_valid_d    = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign out_valid_o = out_valid_q;

endmodule
